>>> rtl/gpio_be_pkg.sv
// Shared types and constants for the GPIO bank with edge events.
package gpio_be_pkg;

  // Default sizing of the bank
  localparam int NUM_PINS_DEF  = 64;
  localparam int BANK_BITS_DEF = 32;
  localparam int MODE_BITS_DEF = 3;

  // Number of function-select words in the word map
  localparam int FSEL_WORDS = 7;

  // Payload widths of the stream channels
  localparam int OPCODE_W   = 2;
  localparam int WORD_W     = 5;
  localparam int DATA_W     = 32;
  localparam int PINS_W     = 64;
  localparam int IN_TDATA_W  = 104;
  localparam int OUT_TDATA_W = 104;

  // Kind of transfer on the input channel
  typedef enum logic [OPCODE_W-1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_TICK  = 2'd2
  } opcode_t;

  // Register word map
  localparam logic [WORD_W-1:0] W_FSEL_FIRST = 5'd0;
  localparam logic [WORD_W-1:0] W_FSEL_LAST  = 5'd6;
  localparam logic [WORD_W-1:0] W_SET0       = 5'd7;
  localparam logic [WORD_W-1:0] W_SET1       = 5'd8;
  localparam logic [WORD_W-1:0] W_CLR0       = 5'd9;
  localparam logic [WORD_W-1:0] W_CLR1       = 5'd10;
  localparam logic [WORD_W-1:0] W_LEV0       = 5'd11;
  localparam logic [WORD_W-1:0] W_LEV1       = 5'd12;
  localparam logic [WORD_W-1:0] W_EDS0       = 5'd13;
  localparam logic [WORD_W-1:0] W_EDS1       = 5'd14;
  localparam logic [WORD_W-1:0] W_REN0       = 5'd15;
  localparam logic [WORD_W-1:0] W_REN1       = 5'd16;
  localparam logic [WORD_W-1:0] W_FEN0       = 5'd17;
  localparam logic [WORD_W-1:0] W_FEN1       = 5'd18;

endpackage

>>> rtl/gpio_bank_with_edge_events.sv
// GPIO bank: set/clear output latch, function select, edge event detect.
//
// Each input transfer is a register read, a register write or a pin sample
// tick, selected by s_tuser. Every transfer yields exactly one result transfer
// carrying the read word (zero unless a read), the output latch and an event
// pending flag, all as they stand after that transfer. The block takes one
// transfer per cycle while the result side is not stalled: all decoding and the
// mask updates sit between the input port and one result register, and a new
// transfer is taken whenever that register is empty or being drained. Pin
// groups of the set, clr, lev, eds, ren and fen words are split into two banks
// of BANK_BITS pins each; function-select fields are packed BANK_BITS/MODE_BITS
// to a word. The first tick after reset compares against an all-low sample.
module gpio_bank_with_edge_events
  import gpio_be_pkg::*;
#(
  parameter int NUM_PINS  = NUM_PINS_DEF,
  parameter int BANK_BITS = BANK_BITS_DEF,
  parameter int MODE_BITS = MODE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // word_index [4:0], write_data [36:5], pin_levels [100:37], zero pad above
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  // opcode [1:0]
  input  logic [OPCODE_W-1:0]    s_tuser,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // read_data [31:0], pin_drive [95:32], event_pending [96], zero pad above
  output logic [OUT_TDATA_W-1:0] m_tdata
);

  localparam int FIELDS = BANK_BITS / MODE_BITS;

  // Unpacked input fields
  opcode_t           opcode;
  logic [WORD_W-1:0] word_index;
  logic [DATA_W-1:0] write_data;
  logic [PINS_W-1:0] pin_levels;

  // Architectural state
  logic [NUM_PINS-1:0]  output_latch;
  logic [NUM_PINS-1:0]  rise_enable;
  logic [NUM_PINS-1:0]  fall_enable;
  logic [NUM_PINS-1:0]  event_status;
  logic [NUM_PINS-1:0]  previous_levels;
  logic [MODE_BITS-1:0] function_select [NUM_PINS];

  logic [NUM_PINS-1:0]  output_latch_next;
  logic [NUM_PINS-1:0]  rise_enable_next;
  logic [NUM_PINS-1:0]  fall_enable_next;
  logic [NUM_PINS-1:0]  event_status_next;
  logic [NUM_PINS-1:0]  previous_levels_next;
  logic [MODE_BITS-1:0] function_select_next [NUM_PINS];

  // Result register
  logic [DATA_W-1:0]   read_data;
  logic [NUM_PINS-1:0] pin_drive;
  logic                event_pending;
  logic [DATA_W-1:0]   read_data_next;

  // Bank helpers
  logic                bank;
  logic [PINS_W-1:0]   data_low;
  logic [PINS_W-1:0]   ones_low;
  logic [NUM_PINS-1:0] bank_data;
  logic [NUM_PINS-1:0] bank_mask;
  logic [DATA_W-1:0]   fsel_word [FSEL_WORDS];

  logic take;

  assign opcode     = opcode_t'(s_tuser);
  assign word_index = s_tdata[4:0];
  assign write_data = s_tdata[36:5];
  assign pin_levels = s_tdata[100:37];

  // Accept whenever the result register is free or draining
  assign s_tready = !m_tvalid || m_tready;
  assign take     = s_tvalid && s_tready;

  // Every group maps its lower bank to the odd word
  assign bank     = !word_index[0];
  assign data_low = PINS_W'(write_data[BANK_BITS-1:0]);
  assign ones_low = PINS_W'({BANK_BITS{1'b1}});
  assign bank_data = bank ? NUM_PINS'(data_low << BANK_BITS) : NUM_PINS'(data_low);
  assign bank_mask = bank ? NUM_PINS'(ones_low << BANK_BITS) : NUM_PINS'(ones_low);

  // Gather the function-select read words from fixed pin positions
  always_comb begin
    int pin;
    for (int w = 0; w < FSEL_WORDS; w++) begin
      fsel_word[w] = '0;
      for (int k = 0; k < FIELDS; k++) begin
        pin = w * FIELDS + k;
        if (pin < NUM_PINS) begin
          fsel_word[w][k*MODE_BITS +: MODE_BITS] = function_select[pin];
        end
      end
    end
  end

  // Select the read word
  function automatic logic [DATA_W-1:0] bank_read(input logic [NUM_PINS-1:0] bits,
                                                  input logic sel);
    logic [PINS_W-1:0] ext;
    ext = PINS_W'(bits);
    if (sel) begin
      ext = ext >> BANK_BITS;
    end
    return DATA_W'(ext[BANK_BITS-1:0]);
  endfunction

  always_comb begin
    read_data_next = '0;
    if (opcode == OP_READ) begin
      case (word_index) inside
        [W_FSEL_FIRST:W_FSEL_LAST]: read_data_next = fsel_word[word_index[2:0]];
        [W_LEV0:W_LEV1]:            read_data_next = bank_read(previous_levels, bank);
        [W_EDS0:W_EDS1]:            read_data_next = bank_read(event_status, bank);
        [W_REN0:W_REN1]:            read_data_next = bank_read(rise_enable, bank);
        [W_FEN0:W_FEN1]:            read_data_next = bank_read(fall_enable, bank);
        default:                    read_data_next = '0;
      endcase
    end
  end

  // Apply writes and ticks to the state
  always_comb begin
    int pin;
    output_latch_next    = output_latch;
    rise_enable_next     = rise_enable;
    fall_enable_next     = fall_enable;
    event_status_next    = event_status;
    previous_levels_next = previous_levels;
    for (int p = 0; p < NUM_PINS; p++) begin
      function_select_next[p] = function_select[p];
    end
    case (opcode)
      OP_WRITE: begin
        case (word_index) inside
          [W_FSEL_FIRST:W_FSEL_LAST]: begin
            for (int w = 0; w < FSEL_WORDS; w++) begin
              for (int k = 0; k < FIELDS; k++) begin
                pin = w * FIELDS + k;
                if (pin < NUM_PINS && word_index == WORD_W'(w)) begin
                  function_select_next[pin] = write_data[k*MODE_BITS +: MODE_BITS];
                end
              end
            end
          end
          [W_SET0:W_SET1]: output_latch_next = output_latch | bank_data;
          [W_CLR0:W_CLR1]: output_latch_next = output_latch & ~bank_data;
          [W_EDS0:W_EDS1]: event_status_next = event_status & ~bank_data;
          [W_REN0:W_REN1]: rise_enable_next  = (rise_enable & ~bank_mask) | bank_data;
          [W_FEN0:W_FEN1]: fall_enable_next  = (fall_enable & ~bank_mask) | bank_data;
          default: ;
        endcase
      end
      OP_TICK: begin
        event_status_next = event_status
          | (NUM_PINS'(pin_levels) & ~previous_levels & rise_enable)
          | (~NUM_PINS'(pin_levels) & previous_levels & fall_enable);
        previous_levels_next = NUM_PINS'(pin_levels);
      end
      default: ;
    endcase
  end

  // Hold state and advance it on each accepted transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      output_latch    <= '0;
      rise_enable     <= '0;
      fall_enable     <= '0;
      event_status    <= '0;
      previous_levels <= '0;
      for (int p = 0; p < NUM_PINS; p++) begin
        function_select[p] <= '0;
      end
    end else if (take) begin
      output_latch    <= output_latch_next;
      rise_enable     <= rise_enable_next;
      fall_enable     <= fall_enable_next;
      event_status    <= event_status_next;
      previous_levels <= previous_levels_next;
      for (int p = 0; p < NUM_PINS; p++) begin
        function_select[p] <= function_select_next[p];
      end
    end
  end

  // Result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_tready) begin
      m_tvalid <= s_tvalid;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (take) begin
      read_data     <= read_data_next;
      pin_drive     <= output_latch_next;
      event_pending <= |event_status_next;
    end
  end

  assign m_tdata = {7'd0, event_pending, PINS_W'(pin_drive), read_data};

endmodule

>>> test/tb_top.sv
// Self-checking stream testbench for the GPIO bank with set/clear latch and edge events.
module tb_top;
  import gpio_be_pkg::*;

  // Codes outside the package map
  localparam logic [OPCODE_W-1:0] OP_UNUSED   = 2'd3;
  localparam logic [WORD_W-1:0]   W_UNMAPPED  = 5'd19;
  localparam logic [WORD_W-1:0]   W_TOP       = 5'd31;

  localparam int FSEL_FIELDS  = BANK_BITS_DEF / MODE_BITS_DEF;
  localparam int RANDOM_ITEMS = 1900;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 8;

  // One result transfer, split into its fields
  typedef struct packed {
    logic [DATA_W-1:0] rd;
    logic [PINS_W-1:0] drive;
    logic              pend;
  } gpio_result_t;

  // One input transfer, with an optional hand-typed expectation
  typedef struct {
    logic [OPCODE_W-1:0] op;
    logic [WORD_W-1:0]   w;
    logic [DATA_W-1:0]   d;
    logic [PINS_W-1:0]   p;
    bit                  typed;
    gpio_result_t        want;
  } gpio_access_t;

  typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_PATTERN} rx_mode_t;

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;
  logic [OPCODE_W-1:0]    s_tuser;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;

  // Predicted bank state
  logic [PINS_W-1:0]        latch_q;
  logic [MODE_BITS_DEF-1:0] fsel_q [PINS_W];
  logic [PINS_W-1:0]        ren_q;
  logic [PINS_W-1:0]        fen_q;
  logic [PINS_W-1:0]        eds_q;
  logic [PINS_W-1:0]        lev_q;

  gpio_result_t results_due [$];
  gpio_access_t plan [$];
  int           failures = 0;
  int           burst_left = 0;

  gpio_bank_with_edge_events i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Apply one access to the predicted state and return the result it yields
  function automatic gpio_result_t gpio_apply(input logic [OPCODE_W-1:0] op,
                                              input logic [WORD_W-1:0] w,
                                              input logic [DATA_W-1:0] d,
                                              input logic [PINS_W-1:0] p);
    gpio_result_t      r;
    int                bank;
    int                pin;
    logic [PINS_W-1:0] span;
    bank = (w == W_SET1 || w == W_CLR1 || w == W_LEV1 || w == W_EDS1 ||
            w == W_REN1 || w == W_FEN1) ? 1 : 0;
    span = {{(PINS_W-DATA_W){1'b0}}, d} << (BANK_BITS_DEF * bank);
    r.rd = '0;
    if (op == OP_READ) begin
      if (w <= W_FSEL_LAST) begin
        for (int k = 0; k < FSEL_FIELDS; k++) begin
          pin = w * FSEL_FIELDS + k;
          if (pin < PINS_W) r.rd[k*MODE_BITS_DEF +: MODE_BITS_DEF] = fsel_q[pin];
        end
      end else if (w == W_LEV0 || w == W_LEV1) begin
        r.rd = lev_q[BANK_BITS_DEF*bank +: DATA_W];
      end else if (w == W_EDS0 || w == W_EDS1) begin
        r.rd = eds_q[BANK_BITS_DEF*bank +: DATA_W];
      end else if (w == W_REN0 || w == W_REN1) begin
        r.rd = ren_q[BANK_BITS_DEF*bank +: DATA_W];
      end else if (w == W_FEN0 || w == W_FEN1) begin
        r.rd = fen_q[BANK_BITS_DEF*bank +: DATA_W];
      end
    end else if (op == OP_WRITE) begin
      if (w <= W_FSEL_LAST) begin
        for (int k = 0; k < FSEL_FIELDS; k++) begin
          pin = w * FSEL_FIELDS + k;
          if (pin < PINS_W) fsel_q[pin] = d[k*MODE_BITS_DEF +: MODE_BITS_DEF];
        end
      end else if (w == W_SET0 || w == W_SET1) begin
        latch_q = latch_q | span;
      end else if (w == W_CLR0 || w == W_CLR1) begin
        latch_q = latch_q & ~span;
      end else if (w == W_EDS0 || w == W_EDS1) begin
        eds_q = eds_q & ~span;
      end else if (w == W_REN0 || w == W_REN1) begin
        ren_q[BANK_BITS_DEF*bank +: DATA_W] = d;
      end else if (w == W_FEN0 || w == W_FEN1) begin
        fen_q[BANK_BITS_DEF*bank +: DATA_W] = d;
      end
    end else if (op == OP_TICK) begin
      // latch enabled edges against the previous sample
      eds_q = eds_q | (p & ~lev_q & ren_q) | (~p & lev_q & fen_q);
      lev_q = p;
    end
    r.drive = latch_q;
    r.pend  = |eds_q;
    return r;
  endfunction

  task automatic add_row(input logic [OPCODE_W-1:0] op, input logic [WORD_W-1:0] w,
                         input logic [DATA_W-1:0] d, input logic [PINS_W-1:0] p,
                         input bit typed, input logic [DATA_W-1:0] rd,
                         input logic [PINS_W-1:0] drive, input logic pend);
    gpio_access_t a;
    a.op = op;
    a.w = w;
    a.d = d;
    a.p = p;
    a.typed = typed;
    a.want = '{rd: rd, drive: drive, pend: pend};
    plan.push_back(a);
  endtask

  // Present one access in a burst, wait for its transfer, record what is due
  task automatic issue(input gpio_access_t a);
    gpio_result_t r;
    int           gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser  <= a.op;
    s_tdata  <= {{(IN_TDATA_W-WORD_W-DATA_W-PINS_W){1'b0}}, a.p, a.d, a.w};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    r = gpio_apply(a.op, a.w, a.d, a.p);
    results_due.push_back(a.typed ? a.want : r);
    @(negedge clk);
  endtask

  task automatic report_field(input string name, input logic [PINS_W-1:0] want,
                              input logic [PINS_W-1:0] got);
    if (want !== got) begin
      failures++;
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
    end
  endtask

  // Check every result transfer against the oldest expectation
  always @(posedge clk) begin
    gpio_result_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (results_due.size() == 0) begin
        failures++;
        $display("%0t: unexpected result: expected none, actual %h", $time, m_tdata);
      end else begin
        e = results_due.pop_front();
        report_field("read_data", PINS_W'(e.rd), PINS_W'(m_tdata[31:0]));
        report_field("pin_drive", e.drive, m_tdata[95:32]);
        report_field("event_pending", PINS_W'(e.pend), PINS_W'(m_tdata[96]));
      end
    end
  end

  // Stall the result side in stretches of differing character
  initial begin : ready_gen
    rx_mode_t   rx_mode;
    int         span_left;
    logic [7:0] pattern;
    m_tready = 1'b0;
    rx_mode = RX_OPEN;
    span_left = 0;
    pattern = 8'hff;
    forever begin
      @(negedge clk);
      if (span_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        span_left = $urandom_range(16, 160);
        pattern = 8'($urandom) | 8'h01;
      end
      span_left--;
      case (rx_mode)
        RX_OPEN: m_tready <= 1'b1;
        RX_COIN: m_tready <= 1'($urandom_range(0, 1));
        RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
        default: begin
          m_tready <= pattern[0];
          pattern = {pattern[0], pattern[7:1]};
        end
      endcase
    end
  end

  // Bound the run
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    gpio_access_t a;
    int           pick;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    latch_q = '0;
    ren_q = '0;
    fen_q = '0;
    eds_q = '0;
    lev_q = '0;
    foreach (fsel_q[i]) fsel_q[i] = '0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: reset values, extremes, slack bits, first tick, ignored accesses
    add_row(OP_READ,  W_FSEL_FIRST, '0, '0, 1, '0, '0, 1'b0);
    add_row(OP_READ,  W_LEV0, '0, '0, 1, '0, '0, 1'b0);
    add_row(OP_WRITE, W_SET0, '1, '0, 1, '0, 64'h0000_0000_ffff_ffff, 1'b0);
    add_row(OP_WRITE, W_SET1, '1, '0, 1, '0, '1, 1'b0);
    add_row(OP_READ,  W_SET0, '1, '0, 1, '0, '1, 1'b0);
    add_row(OP_READ,  W_CLR1, '1, '0, 1, '0, '1, 1'b0);
    add_row(OP_WRITE, W_CLR0, '1, '0, 1, '0, 64'hffff_ffff_0000_0000, 1'b0);
    add_row(OP_WRITE, W_FSEL_FIRST, '1, '0, 0, '0, '0, 1'b0);
    add_row(OP_READ,  W_FSEL_FIRST, '0, '0, 1, 32'h3fff_ffff, 64'hffff_ffff_0000_0000, 1'b0);
    add_row(OP_WRITE, W_FSEL_LAST, '1, '0, 0, '0, '0, 1'b0);
    add_row(OP_READ,  W_FSEL_LAST, '0, '0, 1, 32'h0000_0fff, 64'hffff_ffff_0000_0000, 1'b0);
    add_row(OP_WRITE, W_REN0, '1, '0, 0, '0, '0, 1'b0);
    add_row(OP_WRITE, W_REN1, '1, '0, 0, '0, '0, 1'b0);
    add_row(OP_TICK,  W_FSEL_FIRST, '0, '1, 1, '0, 64'hffff_ffff_0000_0000, 1'b1);
    add_row(OP_READ,  W_EDS0, '0, '0, 1, 32'hffff_ffff, 64'hffff_ffff_0000_0000, 1'b1);
    add_row(OP_WRITE, W_FEN1, 32'h0000_ffff, '0, 0, '0, '0, 1'b0);
    add_row(OP_TICK,  W_TOP, '1, '0, 0, '0, '0, 1'b0);
    add_row(OP_READ,  W_EDS1, '0, '1, 0, '0, '0, 1'b0);
    add_row(OP_WRITE, W_EDS0, '1, '0, 0, '0, '0, 1'b0);
    add_row(OP_WRITE, W_EDS1, '1, '0, 1, '0, 64'hffff_ffff_0000_0000, 1'b0);
    add_row(OP_WRITE, W_LEV0, 32'h1234_5678, '0, 0, '0, '0, 1'b0);
    add_row(OP_READ,  W_LEV1, '0, '0, 0, '0, '0, 1'b0);
    add_row(OP_UNUSED, W_EDS0, '1, '1, 0, '0, '0, 1'b0);
    add_row(OP_READ,  W_TOP, '1, '1, 0, '0, '0, 1'b0);
    add_row(OP_WRITE, W_UNMAPPED, '1, '1, 0, '0, '0, 1'b0);
    add_row(OP_WRITE, W_CLR1, '1, '0, 1, '0, '0, 1'b0);
    foreach (plan[i]) issue(plan[i]);

    // Random: mostly mapped words, pin samples that flip a few bits at a time
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pick = $urandom_range(0, 99);
      a.op = (pick < 35) ? OP_READ : (pick < 70) ? OP_WRITE : (pick < 97) ? OP_TICK : OP_UNUSED;
      a.w = ($urandom_range(0, 15) == 0) ? WORD_W'($urandom_range(W_UNMAPPED, W_TOP))
                                         : WORD_W'($urandom_range(W_FSEL_FIRST, W_FEN1));
      case ($urandom_range(0, 7))
        0: a.d = '1;
        1: a.d = '0;
        2: a.d = 32'd1 << $urandom_range(0, DATA_W-1);
        default: a.d = $urandom;
      endcase
      case ($urandom_range(0, 5))
        0: a.p = {$urandom, $urandom};
        1: a.p = '1;
        2: a.p = '0;
        default: begin
          a.p = lev_q;
          repeat ($urandom_range(1, 4)) a.p[6'($urandom_range(0, PINS_W-1))] ^= 1'b1;
        end
      endcase
      a.typed = 0;
      a.want = '0;
      issue(a);
    end
    s_tvalid <= 1'b0;

    // Drain, then keep watching for any stray result
    while (results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
